>>> src/fsk_period_bit_deframer_top_defines.svh
// ---------------------------------------------------------------------------
// FSK period bit deframer: assertion macros
// Shared helpers for the port checker.
// ---------------------------------------------------------------------------
`ifndef FSK_PERIOD_BIT_DEFRAMER_TOP_DEFINES_SVH
`define FSK_PERIOD_BIT_DEFRAMER_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define FSKPBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FSKPBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fskpbd_pkg.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer package
// Widths, reset values, register indexes and shared types.
// ---------------------------------------------------------------------------
package fskpbd_pkg;

  localparam int PeriodW  = 16;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int BitIdxW  = 4;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [PeriodW-1:0] ShortPeriodRst = 16'd20833;
  localparam logic [PeriodW-1:0] PeriodTolRst   = 16'd12;

  // Bit positions after the start bit: data ends before parity
  localparam logic [BitIdxW-1:0] ParityIdx = 4'd9;

  localparam logic [CfgIdxW-1:0] CFG_SHORT_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD_TOL   = 2'd1;

  typedef enum logic {
    ST_IDLE,
    ST_RECV
  } rx_state_t;

  // One classified tone period: vld marks presence, lvl is the bit level
  typedef struct packed {
    logic vld;
    logic lvl;
  } bit_item_t;

endpackage

>>> src/fskpbd_front.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer: front end
// Holds the configuration registers and turns each period into a bit.
// ---------------------------------------------------------------------------
module fskpbd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fskpbd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [fskpbd_pkg::PeriodW-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fskpbd_pkg::PeriodW-1:0]      in_period_count,
  input  logic                                q_full,
  output fskpbd_pkg::bit_item_t               push
);
  import fskpbd_pkg::*;

  logic [PeriodW-1:0] short_period_r;
  logic [PeriodW-1:0] period_tol_r;
  logic [PeriodW:0]   limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_period_r <= ShortPeriodRst;
      period_tol_r   <= PeriodTolRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_PERIOD: short_period_r <= cfg_data;
        CFG_PERIOD_TOL:   period_tol_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Threshold at full width so the sum never wraps
  assign limit    = {1'b0, short_period_r} + {1'b0, period_tol_r};
  assign in_ready = !q_full;
  assign push.vld = in_valid && !q_full;
  assign push.lvl = ({1'b0, in_period_count} > limit);

endmodule

>>> src/fskpbd_queue.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer: bit queue
// Short FIFO of classified bits between front and back end.
// ---------------------------------------------------------------------------
module fskpbd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fskpbd_pkg::bit_item_t push,
  input  logic                  pop,
  output logic                  full,
  output fskpbd_pkg::bit_item_t head
);
  import fskpbd_pkg::*;

  logic [QDepth-1:0] slot_r;
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign head.vld = (cnt_r != '0);
  assign head.lvl = slot_r[rd_ptr_r];
  assign do_pop   = pop && head.vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.vld) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.vld, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      slot_r[wr_ptr_r] <= push.lvl;
    end
  end

endmodule

>>> src/fskpbd_back.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer: back end
// Frame state machine over classified bits, with the output register.
// ---------------------------------------------------------------------------
module fskpbd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fskpbd_pkg::bit_item_t         head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fskpbd_pkg::ByteW-1:0]  out_received_byte
);
  import fskpbd_pkg::*;

  rx_state_t          state_r, state_nxt;
  logic [BitIdxW-1:0] bit_idx_r, bit_idx_nxt;
  logic [ByteW-1:0]   shift_r, shift_nxt;
  logic               parity_r, parity_nxt;
  logic               skip_r, skip_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ByteW-1:0]   out_byte_r, out_byte_nxt;
  logic [BitIdxW-1:0] idx_inc;
  logic               take;

  // Advance whenever a bit waits and the output slot is free or draining
  assign take    = head.vld && (!out_valid_r || out_ready);
  assign pop     = take;
  assign idx_inc = bit_idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    parity_nxt    = parity_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    if (take) begin
      case (state_r)
        ST_IDLE: begin
          // Short period opens a frame; long ones are ignored
          if (!head.lvl) begin
            state_nxt   = ST_RECV;
            bit_idx_nxt = '0;
            shift_nxt   = '0;
            parity_nxt  = 1'b1;
            skip_nxt    = 1'b1;
          end
        end
        ST_RECV: begin
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else begin
            skip_nxt    = !head.lvl;
            bit_idx_nxt = idx_inc;
            if (idx_inc == ParityIdx) begin
              if (parity_r != head.lvl) begin
                state_nxt = ST_IDLE;
              end
            end else if (idx_inc > ParityIdx) begin
              // Stop bit: emit on 1, drop the frame on 0
              state_nxt = ST_IDLE;
              if (head.lvl) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = shift_r;
              end
            end else begin
              shift_nxt  = {head.lvl, shift_r[ByteW-1:1]};
              parity_nxt = parity_r ^ head.lvl;
            end
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      parity_r    <= 1'b1;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      parity_r    <= parity_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_received_byte = out_byte_r;

endmodule

>>> src/fsk_period_bit_deframer_top.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer
// Classifies tone periods into bits and unpacks odd-parity serial frames.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data
//  in      | in        | in_valid / in_ready   | in_period_count[15:0]
//  out     | out       | out_valid / out_ready | out_received_byte[7:0]
//
//  One period per cycle is accepted while the bit queue has room; the compare
//  writes the bit queue at the accepting edge, and the frame update reads it
//  from the queue head and registers out_valid once the stop period arrives.
//  The back end holds while a byte is stalled at the output; the two-entry
//  bit queue absorbs two periods meanwhile, and in_ready drops once it is full.
//  Synchronous reset restores the default threshold and returns to idle.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
module fsk_period_bit_deframer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fskpbd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [fskpbd_pkg::PeriodW-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fskpbd_pkg::PeriodW-1:0]    in_period_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fskpbd_pkg::ByteW-1:0]      out_received_byte
);
  import fskpbd_pkg::*;

  bit_item_t push;
  bit_item_t head;
  logic      q_full;
  logic      pop;

  fskpbd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_period_count (in_period_count),
    .q_full          (q_full),
    .push            (push)
  );

  fskpbd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  fskpbd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_received_byte (out_received_byte)
  );

endmodule

>>> src/fskpbd_checker.sv
// ---------------------------------------------------------------------------
// FSK period bit deframer: port checker
// Watches the top-level ports for handshake and reset behavior.
// ---------------------------------------------------------------------------
`include "fsk_period_bit_deframer_top_defines.svh"

module fskpbd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_ready,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fskpbd_pkg::ByteW-1:0]      out_received_byte
);
  import fskpbd_pkg::*;

  `FSKPBD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_received_byte), "stalled byte changed or vanished")
  `FSKPBD_ASSERT(a_rst_in_ready, clk, rst_n, $past(!rst_n) |-> in_ready, "input not ready after reset")
  `FSKPBD_ASSERT(a_rst_out_idle, clk, rst_n, $past(!rst_n) |-> !out_valid, "byte shown right after reset")
  `FSKPBD_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "configuration port stalled")

endmodule

bind fsk_period_bit_deframer_top fskpbd_checker u_fskpbd_checker (.*);
